// File: hw/rtl/min_max_contrast_stretch_core_defines.svh
// ----------------------------------------------------------------------------
// Min/max contrast stretch assertion macros
// Shared concurrent assertion forms for the stretch core checkers.
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_CONTRAST_STRETCH_CORE_DEFINES_SVH
`define MIN_MAX_CONTRAST_STRETCH_CORE_DEFINES_SVH

// Next-cycle implication, ignored while reset is high.
`define MMCS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("stretch core check failed");

// Next-cycle implication that also holds across reset.
`define MMCS_ASSERT_NEXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("stretch core reset check failed");

`endif

// File: hw/rtl/mmcs_pkg.sv
// ----------------------------------------------------------------------------
// Min/max contrast stretch package
// Widths, request types and control structs shared by the stretch core.
// ----------------------------------------------------------------------------
package mmcs_pkg;

  localparam int PIXEL_BITS = 16;
  localparam int FIELD_BITS = 16;
  localparam int CNT_BITS   = $clog2(PIXEL_BITS);

  localparam logic [PIXEL_BITS-1:0] FULL_SCALE = {PIXEL_BITS{1'b1}};
  localparam logic [PIXEL_BITS-1:0] LOW_RESET  = FULL_SCALE;
  localparam logic [PIXEL_BITS-1:0] HIGH_RESET = '0;

  localparam logic MODE_MEASURE   = 1'b0;
  localparam logic MODE_NORMALIZE = 1'b1;

  typedef struct packed {
    logic                  mode;
    logic [FIELD_BITS-1:0] pixel;
    logic                  last;
  } in_req_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] stretched;
    logic                  end_of_frame;
  } out_req_t;

  typedef struct packed {
    logic update;
    logic clear;
  } bnd_ctl_t;

  typedef struct packed {
    logic                  done;
    logic [PIXEL_BITS-1:0] quotient;
  } div_res_t;

endpackage

// File: hw/rtl/mmcs_bounds.sv
// ----------------------------------------------------------------------------
// Min/max contrast stretch bounds tracker
// Holds the running minimum and maximum of the measure pass.
// ----------------------------------------------------------------------------
module mmcs_bounds (
  input  logic                           clk,
  input  logic                           rst,
  input  mmcs_pkg::bnd_ctl_t             ctl,
  input  logic [mmcs_pkg::PIXEL_BITS-1:0] pixel,
  output logic [mmcs_pkg::PIXEL_BITS-1:0] low_bound,
  output logic [mmcs_pkg::PIXEL_BITS-1:0] high_bound
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      low_bound  <= mmcs_pkg::LOW_RESET;
      high_bound <= mmcs_pkg::HIGH_RESET;
    end else if (ctl.update) begin
      if (pixel < low_bound) begin
        low_bound <= pixel;
      end
      if (pixel > high_bound) begin
        high_bound <= pixel;
      end
    end
  end

endmodule

// File: hw/rtl/mmcs_div.sv
// ----------------------------------------------------------------------------
// Min/max contrast stretch serial divider
// Restoring divider producing one quotient bit per cycle of d*FULL/range.
// ----------------------------------------------------------------------------
module mmcs_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [mmcs_pkg::PIXEL_BITS-1:0] offset,
  input  logic [mmcs_pkg::PIXEL_BITS-1:0] range,
  output mmcs_pkg::div_res_t              res
);

  localparam int PB = mmcs_pkg::PIXEL_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FIX
  } div_state_t;

  div_state_t                    state;
  logic [PB:0]                   rem;
  logic [PB-1:0]                 den;
  logic [PB-1:0]                 quo;
  logic [PB-1:0]                 base;
  logic [mmcs_pkg::CNT_BITS-1:0] cnt;

  logic [PB:0]   shifted;
  logic [PB+1:0] diff;

  // The numerator is offset*2^PB - offset; the long division runs on offset*2^PB and
  // the final step decrements the quotient when the remainder is below the offset.
  assign shifted = {rem[PB-1:0], 1'b0};
  assign diff    = {1'b0, shifted} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      res.done <= 1'b0;
      cnt      <= '0;
    end else begin
      res.done <= (state == ST_FIX);
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            rem   <= {1'b0, offset};
            den   <= range;
            base  <= offset;
            quo   <= '0;
            cnt   <= '0;
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (!diff[PB+1]) begin
            rem <= diff[PB:0];
            quo <= {quo[PB-2:0], 1'b1};
          end else begin
            rem <= shifted;
            quo <= {quo[PB-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == mmcs_pkg::CNT_BITS'(PB - 1)) begin
            state <= ST_FIX;
          end
        end
        ST_FIX: begin
          res.quotient <= (rem[PB-1:0] >= base) ? quo : quo - 1'b1;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/min_max_contrast_stretch_core.sv
// ----------------------------------------------------------------------------
// Min/max contrast stretch core
// Measures the pixel range of a frame, then stretches each pixel to full scale.
//
//   channel   signals                      request fields
//   in        in_valid, in_ready, in_data  mode, pixel, last
//   out       out_valid, out_ready, out_data stretched, end_of_frame
//
// A measure request gives no result.
// A normalize request in range loads the output register once the output is free,
// after 16 divider steps, one correction, one capture and one load.
// Below, above or without a measured range it goes to the hold state and loads from there.
// Reset returns the bounds to an empty range and empties the output register.
// A stalled output holds its request; a new input request is taken meanwhile.
// ----------------------------------------------------------------------------
module min_max_contrast_stretch_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mmcs_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mmcs_pkg::out_req_t out_data
);

  localparam int PB = mmcs_pkg::PIXEL_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_HOLD
  } core_state_t;

  core_state_t        state;
  logic [PB-1:0]      result;
  logic               result_last;

  logic               accept;
  logic [PB-1:0]      pixel;
  logic [PB-1:0]      low_bound;
  logic [PB-1:0]      high_bound;
  mmcs_pkg::bnd_ctl_t bnd_ctl;
  mmcs_pkg::div_res_t div_res;
  logic               div_start;
  logic               no_range;
  logic               saturate;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign pixel    = in_data.pixel[PB-1:0];

  assign bnd_ctl.update = accept && (in_data.mode == mmcs_pkg::MODE_MEASURE);
  assign bnd_ctl.clear  = accept && (in_data.mode == mmcs_pkg::MODE_NORMALIZE)
                          && in_data.last;

  assign no_range  = (high_bound <= low_bound) || (pixel <= low_bound);
  assign saturate  = (pixel >= high_bound);
  assign div_start = accept && (in_data.mode == mmcs_pkg::MODE_NORMALIZE)
                     && !no_range && !saturate;

  mmcs_bounds u_bounds (
    .clk        (clk),
    .rst        (rst),
    .ctl        (bnd_ctl),
    .pixel      (pixel),
    .low_bound  (low_bound),
    .high_bound (high_bound)
  );

  mmcs_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .offset (pixel - low_bound),
    .range  (high_bound - low_bound),
    .res    (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_HOLD)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (in_data.mode == mmcs_pkg::MODE_NORMALIZE)) begin
            result_last <= in_data.last;
            if (no_range) begin
              result <= '0;
              state  <= ST_HOLD;
            end else if (saturate) begin
              result <= mmcs_pkg::FULL_SCALE;
              state  <= ST_HOLD;
            end else begin
              state <= ST_BUSY;
            end
          end
        end
        ST_BUSY: begin
          if (div_res.done) begin
            result <= div_res.quotient;
            state  <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!out_valid || out_ready) begin
            out_valid             <= 1'b1;
            out_data.stretched    <= mmcs_pkg::FIELD_BITS'(result);
            out_data.end_of_frame <= result_last;
            state                 <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/mmcs_checker.sv
// ----------------------------------------------------------------------------
// Min/max contrast stretch port checker
// Watches the core's ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "min_max_contrast_stretch_core_defines.svh"

module mmcs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input mmcs_pkg::in_req_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input mmcs_pkg::out_req_t out_data
);

  `MMCS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `MMCS_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)
  `MMCS_ASSERT_NEXT(a_measure_silent, clk, rst, in_valid && in_ready && !out_valid && (in_data.mode == mmcs_pkg::MODE_MEASURE), !out_valid)
  `MMCS_ASSERT_NEXT(a_normalize_busy, clk, rst, in_valid && in_ready && (in_data.mode == mmcs_pkg::MODE_NORMALIZE), !in_ready)

endmodule

bind min_max_contrast_stretch_core mmcs_checker u_mmcs_checker (.*);
